### design/ssc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, codes, segment patterns and digit helpers for the
// seven-segment scan controller.
// ----------------------------------------------------------------------------
package ssc_pkg;

    // opcodes
    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_VIN  = 3'd1;
    localparam logic [2:0] OP_VOUT = 3'd2;
    localparam logic [2:0] OP_CUR  = 3'd3;
    localparam logic [2:0] OP_CONF = 3'd4;

    // update kinds
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_SLOW = 2'd1;
    localparam logic [1:0] MODE_FAST = 2'd2;

    localparam logic [15:0] REFRESH_HOLD_RESET = 16'd50;

    // digit select pattern
    localparam logic [15:0] SEL_BASE = 16'hFF00;
    localparam logic [15:0] SEL_PAIR = 16'h0300;

    // letters and dot
    localparam logic [7:0] SEG_E   = 8'h9E;
    localparam logic [7:0] SEG_V   = 8'h7C;
    localparam logic [7:0] SEG_A   = 8'hEE;
    localparam logic [7:0] SEG_C   = 8'h9C;
    localparam logic [7:0] SEG_O   = 8'hFC;
    localparam logic [7:0] SEG_N   = 8'hEC;
    localparam logic [7:0] SEG_F   = 8'h8E;
    localparam logic [7:0] SEG_DOT = 8'h01;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [3:0]  digit;
        logic [15:0] rem;
    } digit_t;

    // word between front and back
    typedef struct packed {
        logic            is_tick;
        logic [1:0]      mode;
        logic [3:0][7:0] segs;
    } cmd_t;

    // one decimal digit at a constant place, by parallel compares
    function automatic digit_t split_digit(input logic [15:0] x, input logic [16:0] place);
        digit_t      r;
        logic [20:0] prod;
        r.digit = '0;
        for (int k = 1; k < 10; k++) begin
            if ({5'd0, x} >= 21'(k) * {4'd0, place}) begin
                r.digit = 4'(k);
            end
        end
        prod  = {17'd0, r.digit} * {4'd0, place};
        r.rem = x - prod[15:0];
        return r;
    endfunction

    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0:    s = 8'hFC;
            4'd1:    s = 8'h60;
            4'd2:    s = 8'hDA;
            4'd3:    s = 8'hF2;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'hB6;
            4'd6:    s = 8'hBE;
            4'd7:    s = 8'hE0;
            4'd8:    s = 8'hFE;
            4'd9:    s = 8'hF6;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

### design/seven_segment_scan_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_scan_controller
// Four-digit multiplexed seven-segment driver with pending and shown buffers.
// ----------------------------------------------------------------------------
// Takes one word per clock on the s_ channel while s_ready is high. Show words
// (opcodes 1 to 4) fill the pending buffer and arm the update kind they carry;
// they produce no output. Each tick word produces one 16-bit frame on the m_
// channel, shifted out LSB first by the user and then latched. A word passes
// two front stages (decimal split of the value), a four-entry queue and the
// output register. Words are taken at one per cycle while m_ready keeps the
// single output register draining; the queue lets show words keep flowing
// while a frame waits. refresh_hold is written on the cfg_ channel; the
// user must write it only while no word is in flight, and the block does
// not enforce this.
// ----------------------------------------------------------------------------
module seven_segment_scan_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [15:0] s_value,
    input  logic [1:0]  s_update_kind,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_frame_word,
    output logic [1:0]  m_digit_index,
    output logic        m_buffer_copied,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [15:0]   refresh_hold_reg, refresh_hold_next;
    logic          fq_valid, fq_ready, qb_valid, qb_ready;
    ssc_pkg::cmd_t fq_cmd, qb_cmd;

    assign cfg_ready         = 1'b1;
    assign refresh_hold_next = (cfg_valid && cfg_ready) ? cfg_data : refresh_hold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            refresh_hold_reg <= ssc_pkg::REFRESH_HOLD_RESET;
        end else begin
            refresh_hold_reg <= refresh_hold_next;
        end
    end

    ssc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_value       (s_value),
        .s_update_kind (s_update_kind),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_cmd         (fq_cmd)
    );

    ssc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    ssc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .refresh_hold    (refresh_hold_reg),
        .q_valid         (qb_valid),
        .q_ready         (qb_ready),
        .q_cmd           (qb_cmd),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_word    (m_frame_word),
        .m_digit_index   (m_digit_index),
        .m_buffer_copied (m_buffer_copied)
    );

endmodule

### design/ssc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_front
// Accepts items, drops unused opcodes, splits the value into decimal digits
// over two stages and builds the segment word for the queue.
// ----------------------------------------------------------------------------
module ssc_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [2:0]    s_opcode,
    input  logic [15:0]   s_value,
    input  logic [1:0]    s_update_kind,
    output logic          q_valid,
    input  logic          q_ready,
    output ssc_pkg::cmd_t q_cmd
);

    logic        v1_reg, v1_next;
    logic [2:0]  op1_reg;
    logic [1:0]  kind1_reg;
    logic [2:0]  d0_1_reg;
    logic [13:0] r1_reg;

    logic        v2_reg, v2_next;
    logic [2:0]  op2_reg;
    logic [1:0]  kind2_reg;
    logic [2:0]  d0_2_reg;
    logic [3:0]  d1_2_reg;
    logic [9:0]  r2_reg;

    ssc_pkg::digit_t dig0, dig1, dig2, dig3;
    logic            ld1, adv1, s2_free;
    logic [7:0]      seg_a, seg_b, seg_c;
    logic [7:0]      s0, s1, s2, s3;
    logic            hi_nonzero;

    assign s2_free = !v2_reg || q_ready;
    assign adv1    = v1_reg && s2_free;
    assign s_ready = !v1_reg || adv1;
    // unused opcodes are taken and dropped here
    assign ld1     = s_valid && (s_opcode <= ssc_pkg::OP_CONF);

    assign dig0 = ssc_pkg::split_digit(s_value, 17'd10000);
    assign dig1 = ssc_pkg::split_digit({2'd0, r1_reg}, 17'd1000);

    assign v1_next = s_ready ? ld1 : v1_reg;
    assign v2_next = s2_free ? v1_reg : v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && ld1) begin
            op1_reg   <= s_opcode;
            kind1_reg <= s_update_kind;
            d0_1_reg  <= dig0.digit[2:0];
            r1_reg    <= dig0.rem[13:0];
        end
        if (adv1) begin
            op2_reg   <= op1_reg;
            kind2_reg <= kind1_reg;
            d0_2_reg  <= d0_1_reg;
            d1_2_reg  <= dig1.digit;
            r2_reg    <= dig1.rem[9:0];
        end
    end

    // hundreds then tens, both on narrow values
    assign dig2 = ssc_pkg::split_digit({6'd0, r2_reg}, 17'd100);
    assign dig3 = ssc_pkg::split_digit(dig2.rem, 17'd10);

    assign hi_nonzero = (d0_2_reg != 3'd0);
    assign seg_a = hi_nonzero ? ssc_pkg::seg_of({1'b0, d0_2_reg})
                              : (ssc_pkg::seg_of(d1_2_reg) | ssc_pkg::SEG_DOT);
    assign seg_b = hi_nonzero ? (ssc_pkg::seg_of(d1_2_reg) | ssc_pkg::SEG_DOT)
                              : ssc_pkg::seg_of(dig2.digit);
    assign seg_c = hi_nonzero ? ssc_pkg::seg_of(dig2.digit)
                              : ssc_pkg::seg_of(dig3.digit);

    always_comb begin
        s3 = seg_a;
        s2 = seg_b;
        s1 = seg_c;
        s0 = ssc_pkg::SEG_V;
        unique case (op2_reg)
            ssc_pkg::OP_VIN: begin
                s3 = ssc_pkg::SEG_E;
                s2 = seg_a;
                s1 = seg_b;
                s0 = seg_c;
            end
            ssc_pkg::OP_CUR: begin
                s0 = ssc_pkg::SEG_A;
            end
            ssc_pkg::OP_CONF: begin
                s3 = ssc_pkg::SEG_C;
                s2 = ssc_pkg::SEG_O;
                s1 = ssc_pkg::SEG_N;
                s0 = ssc_pkg::SEG_F | ssc_pkg::SEG_DOT;
            end
            default: begin
                s0 = ssc_pkg::SEG_V;
            end
        endcase
    end

    assign q_valid      = v2_reg;
    assign q_cmd.is_tick = (op2_reg == ssc_pkg::OP_TICK);
    assign q_cmd.mode    = kind2_reg;
    assign q_cmd.segs    = {s3, s2, s1, s0};

endmodule

### design/ssc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_queue
// Short in-order queue of command words between front and back.
// ----------------------------------------------------------------------------
module ssc_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  ssc_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output ssc_pkg::cmd_t out_cmd
);

    localparam int PW = $clog2(ssc_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(ssc_pkg::QUEUE_DEPTH + 1);

    ssc_pkg::cmd_t   mem [ssc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign in_ready  = (count_reg != CW'(ssc_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = mem[rd_ptr_reg];

    assign wr_ptr_next = push ? PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
    assign rd_ptr_next = pop ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
    assign count_next  = CW'(count_reg + CW'(push) - CW'(pop));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### design/ssc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_back
// Holds pending and shown buffers, the hold counter and the scan position;
// applies writes and turns ticks into frame words.
// ----------------------------------------------------------------------------
module ssc_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [15:0]   refresh_hold,
    input  logic          q_valid,
    output logic          q_ready,
    input  ssc_pkg::cmd_t q_cmd,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [15:0]   m_frame_word,
    output logic [1:0]    m_digit_index,
    output logic          m_buffer_copied
);

    logic [3:0][7:0] pending_reg, shown_reg;
    logic [3:0][7:0] shown_next, shown_sel;
    logic [1:0]      mode_reg, mode_next;
    logic [15:0]     hold_reg, hold_next, hold_dec;
    logic [1:0]      scan_reg, scan_next;
    logic            m_valid_reg, m_valid_next;
    logic [15:0]     frame_reg, frame_next;
    logic [1:0]      index_reg;
    logic            copied_reg;
    logic            pop, pop_tick, pop_write, copy;
    logic [15:0]     sel;

    assign q_ready   = !q_cmd.is_tick || !m_valid_reg || m_ready;
    assign pop       = q_valid && q_ready;
    assign pop_tick  = pop && q_cmd.is_tick;
    assign pop_write = pop && !q_cmd.is_tick;

    // counter steps down before the slow-update check
    assign hold_dec  = (hold_reg != 16'd0) ? hold_reg - 16'd1 : 16'd0;
    assign copy      = ((mode_reg == ssc_pkg::MODE_SLOW) && (hold_dec == 16'd0))
                       || (mode_reg == ssc_pkg::MODE_FAST);
    assign shown_sel = copy ? pending_reg : shown_reg;

    assign sel        = ssc_pkg::SEL_BASE ^ (ssc_pkg::SEL_PAIR << {scan_reg, 1'b0});
    assign frame_next = sel | {8'h00, shown_sel[scan_reg]};

    assign shown_next = pop_tick ? shown_sel : shown_reg;
    assign scan_next  = pop_tick ? 2'(scan_reg + 1'b1) : scan_reg;

    always_comb begin
        mode_next = mode_reg;
        hold_next = hold_reg;
        if (pop_write) begin
            mode_next = q_cmd.mode;
        end else if (pop_tick) begin
            hold_next = copy ? refresh_hold : hold_dec;
            if (copy) begin
                mode_next = ssc_pkg::MODE_NONE;
            end
        end
    end

    always_comb begin
        priority if (pop_tick) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            shown_reg   <= '0;
            mode_reg    <= ssc_pkg::MODE_NONE;
            hold_reg    <= '0;
            scan_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop_write) begin
                pending_reg <= q_cmd.segs;
            end
            shown_reg   <= shown_next;
            mode_reg    <= mode_next;
            hold_reg    <= hold_next;
            scan_reg    <= scan_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_tick) begin
            frame_reg  <= frame_next;
            index_reg  <= scan_reg;
            copied_reg <= copy;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_word    = frame_reg;
    assign m_digit_index   = index_reg;
    assign m_buffer_copied = copied_reg;

endmodule

### tb/tb_seven_segment_scan_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seven_segment_scan_controller
// Self-checking bench for the four-digit seven-segment scan controller.
// ----------------------------------------------------------------------------
// Each accepted word on s_ goes into a local copy of the display state:
// pending and shown segment buffers, the armed update kind, the hold counter
// and the scan position. Every tick yields one predicted frame. Frames on m_
// are checked field by field, in order, against those predictions. Directed
// words cover the number formats, the letters, the confirm word, ignored
// opcodes and odd update kinds. Random phases follow, each run under its own
// refresh_hold value; all but one add random gaps on s_ and stalls on m_.
// ----------------------------------------------------------------------------
module tb_seven_segment_scan_controller;
    import ssc_pkg::*;

    localparam int          LIMIT     = 400000;
    localparam int          SETTLE    = 16;
    localparam logic [2:0]  OP_LAST   = 3'd7;
    localparam logic [1:0]  MODE_HELD = 2'd3;

    typedef struct {
        logic [15:0] frame;
        logic [1:0]  digit;
        logic        copied;
    } frame_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_opcode;
    logic [15:0] s_value;
    logic [1:0]  s_update_kind;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_frame_word;
    logic [1:0]  m_digit_index;
    logic        m_buffer_copied;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // display model
    logic [15:0] hold_reg;
    logic [15:0] hold_cnt;
    logic [1:0]  scan_pos;
    logic [1:0]  pend_mode;
    logic [7:0]  pend_segs  [4];
    logic [7:0]  shown_segs [4];

    frame_t frames_due [$];

    int  errors;
    int  cycles;
    int  ticks_sent;
    int  shows_sent;
    int  ignored_sent;
    int  copies_seen;
    int  hold_settings;
    bit  calm;

    seven_segment_scan_controller dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_value         (s_value),
        .s_update_kind   (s_update_kind),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_word    (m_frame_word),
        .m_digit_index   (m_digit_index),
        .m_buffer_copied (m_buffer_copied),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic logic [7:0] digit_pattern(input int d);
        case (d)
            0:       return 8'hFC;
            1:       return 8'h60;
            2:       return 8'hDA;
            3:       return 8'hF2;
            4:       return 8'h66;
            5:       return 8'hB6;
            6:       return 8'hBE;
            7:       return 8'hE0;
            8:       return 8'hFE;
            default: return 8'hF6;
        endcase
    endfunction

    // three digits from the top place down; the thousands digit gets the dot
    task automatic load_number(input logic [15:0] v, input int top);
        int         place;
        logic [7:0] seg;
        place = (v >= 16'd10000) ? 10000 : 1000;
        for (int n = 0; n < 3; n++) begin
            seg = digit_pattern((int'(v) / place) % 10);
            if (place == 1000) begin
                seg = seg | SEG_DOT;
            end
            pend_segs[(top - n) & 3] = seg;
            place = place / 10;
        end
    endtask

    task automatic apply_word(input logic [2:0] op, input logic [15:0] v,
                              input logic [1:0] kind);
        frame_t f;
        int     p;
        if (op == OP_TICK) begin
            p        = scan_pos;
            scan_pos = scan_pos + 2'd1;
            if (hold_cnt != 16'd0) begin
                hold_cnt = hold_cnt - 16'd1;
            end
            f.copied = (pend_mode == MODE_SLOW && hold_cnt == 16'd0) || pend_mode == MODE_FAST;
            if (f.copied) begin
                shown_segs = pend_segs;
                pend_mode  = MODE_NONE;
                hold_cnt   = hold_reg;
            end
            f.frame = (SEL_BASE & ~(SEL_PAIR << (2 * p))) | {8'h00, shown_segs[p]};
            f.digit = 2'(p);
            frames_due.push_back(f);
            ticks_sent++;
            return;
        end
        case (op)
            OP_VIN: begin
                pend_segs[3] = SEG_E;
                load_number(v, 2);
            end
            OP_VOUT: begin
                pend_segs[0] = SEG_V;
                load_number(v, 3);
            end
            OP_CUR: begin
                pend_segs[0] = SEG_A;
                load_number(v, 3);
            end
            OP_CONF: begin
                pend_segs[3] = SEG_C;
                pend_segs[2] = SEG_O;
                pend_segs[1] = SEG_N;
                pend_segs[0] = SEG_F | SEG_DOT;
            end
            default: begin
                ignored_sent++;
                return;
            end
        endcase
        pend_mode = kind;
        shows_sent++;
    endtask

    // model update on accepted words, frame check on accepted results
    always @(posedge aclk) begin
        frame_t f;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                hold_reg = cfg_data;
            end
            if (s_valid && s_ready) begin
                apply_word(s_opcode, s_value, s_update_kind);
            end
            if (m_valid && m_ready) begin
                if (m_buffer_copied) begin
                    copies_seen++;
                end
                if (frames_due.size() == 0) begin
                    $display("%0t: unexpected frame %h digit %0d copied %0b", $realtime,
                             m_frame_word, m_digit_index, m_buffer_copied);
                    errors++;
                end else begin
                    f = frames_due.pop_front();
                    if (m_frame_word !== f.frame) begin
                        $display("%0t: frame_word expected %h actual %h", $realtime,
                                 f.frame, m_frame_word);
                        errors++;
                    end
                    if (m_digit_index !== f.digit) begin
                        $display("%0t: digit_index expected %0d actual %0d", $realtime,
                                 f.digit, m_digit_index);
                        errors++;
                    end
                    if (m_buffer_copied !== f.copied) begin
                        $display("%0t: buffer_copied expected %0b actual %0b", $realtime,
                                 f.copied, m_buffer_copied);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_ready <= (!calm && $urandom_range(0, 99) < 27) ? 1'b0 : 1'b1;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d frames outstanding", $realtime,
                     cycles, frames_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // valid stays high between back-to-back words; each idle cycle lowers it first
    task automatic send_word(input logic [2:0] op, input logic [15:0] v,
                             input logic [1:0] kind);
        while (!calm && $urandom_range(0, 99) < 27) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_value       <= v;
        s_update_kind <= kind;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_tick();
        send_word(OP_TICK, 16'($urandom), 2'($urandom));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_hold(input logic [15:0] h);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= h;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        hold_settings++;
    endtask

    task automatic test_reset_frames();
        send_tick();
        send_tick();
    endtask

    task automatic test_number_formats();
        send_word(OP_VIN, 16'd0, MODE_FAST);
        send_tick();
        send_word(OP_VIN, 16'hFFFF, MODE_FAST);
        send_tick();
        send_word(OP_VOUT, 16'd9999, MODE_FAST);
        send_tick();
        send_word(OP_CUR, 16'd10000, MODE_FAST);
        send_tick();
        send_word(OP_CONF, 16'h5A5A, MODE_FAST);
        send_tick();
        send_word(OP_VOUT, 16'd99, MODE_SLOW);
        send_tick();
    endtask

    task automatic test_odd_words();
        // unused opcodes leave everything alone
        send_word(OP_LAST, 16'hFFFF, MODE_HELD);
        send_word(OP_CONF + 3'd1, 16'hAAAA, MODE_FAST);
        send_word(OP_LAST - 3'd1, 16'h5555, MODE_SLOW);
        // kind three arms nothing
        send_word(OP_CUR, 16'd1234, MODE_HELD);
        send_tick();
        send_tick();
        // kind none cancels an armed slow update
        send_word(OP_VIN, 16'd500, MODE_SLOW);
        send_word(OP_VOUT, 16'd7, MODE_NONE);
        send_tick();
    endtask

    task automatic test_random(input int n, input logic [15:0] h, input bit quiet);
        int          r;
        int          sent;
        logic [2:0]  op;
        logic [15:0] v;
        logic [1:0]  kind;
        calm = 1'b0;
        write_hold(h);
        calm = quiet;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                op = OP_TICK;
            end else if (r < 92) begin
                op = 3'($urandom_range(OP_VIN, OP_CONF));
            end else begin
                op = 3'($urandom_range(OP_CONF + 3'd1, OP_LAST));
            end
            if ($urandom_range(0, 99) < 20) begin
                case ($urandom_range(0, 4))
                    0:       v = 16'd0;
                    1:       v = 16'hFFFF;
                    2:       v = 16'd9999;
                    3:       v = 16'd10000;
                    default: v = 16'($urandom_range(0, 999));
                endcase
            end else begin
                v = 16'($urandom);
            end
            r = $urandom_range(0, 99);
            if (r < 40) begin
                kind = MODE_SLOW;
            end else if (r < 75) begin
                kind = MODE_FAST;
            end else if (r < 90) begin
                kind = MODE_NONE;
            end else begin
                kind = MODE_HELD;
            end
            send_word(op, v, kind);
            if (op <= OP_CONF) begin
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        aclk          = 1'b0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_opcode     <= OP_TICK;
        s_value      <= 16'd0;
        s_update_kind <= MODE_NONE;
        cfg_valid    <= 1'b0;
        cfg_data     <= 16'd0;
        errors        = 0;
        cycles        = 0;
        ticks_sent    = 0;
        shows_sent    = 0;
        ignored_sent  = 0;
        copies_seen   = 0;
        hold_settings = 0;
        calm          = 1'b0;
        hold_reg      = REFRESH_HOLD_RESET;
        hold_cnt      = 16'd0;
        scan_pos      = 2'd0;
        pend_mode     = MODE_NONE;
        for (int i = 0; i < 4; i++) begin
            pend_segs[i]  = 8'h00;
            shown_segs[i] = 8'h00;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_frames();
        test_number_formats();
        test_odd_words();
        test_random(300, 16'd0, 1'b0);
        test_random(300, 16'd1, 1'b1);
        test_random(300, 16'd3, 1'b0);
        test_random(250, 16'hFFFF, 1'b0);
        test_random(300, 16'd7, 1'b0);
        test_random(300, REFRESH_HOLD_RESET, 1'b0);

        wait_drained();
        if (frames_due.size() != 0) begin
            $display("%0t: %0d frames never arrived", $realtime, frames_due.size());
            errors++;
        end
        $display("covered %0d ticks, %0d show words, %0d ignored words", ticks_sent,
                 shows_sent, ignored_sent);
        $display("saw %0d buffer copies over %0d hold settings, %0d errors", copies_seen,
                 hold_settings, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
